// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ===== rtl/core/gtpq_pkg.sv =====
// Types and codes for the generation tagged priority queue.
// No dependencies; imported by the queue top level.
package gtpq_pkg;

    typedef enum logic [1:0] {
        FUNC_SUBMIT  = 2'd0,
        FUNC_DEQUEUE = 2'd1,
        FUNC_BUMP    = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_FULL  = 3'd1,
        STAT_EMPTY = 3'd2,
        STAT_STALE = 3'd3,
        STAT_BUMP  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_PUT,
        ST_HEAD,
        ST_WALK
    } t_state;

    typedef struct packed {
        t_func       func;
        logic [15:0] job_tag;
        logic [3:0]  job_priority;
        logic        job_pinned;
        logic [15:0] job_generation;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [15:0] out_tag;
        logic [3:0]  out_priority;
        logic        out_pinned;
        logic [4:0]  dropped_count;
        logic [4:0]  occupancy;
        logic [15:0] current_generation;
    } t_rsp;

endpackage

// ===== rtl/core/gtpq_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies; used for the queue entry store.
module gtpq_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/generation_tagged_priority_queue.sv =====
// Generation tagged priority queue: top level with its sequencer and entry RAM.
// Depends on gtpq_pkg, gtpq_ram and assert_macros.svh.
//
// Usage:
//   A request (i_req) is taken at a rising edge with start high and busy low.
//   Every request gives exactly one result on o_rsp, valid for one cycle while
//   o_done is high; the receiver cannot stall, so it must take it then.
//   Entries live in one RAM, kept sorted by priority (lower first, equal
//   priorities in arrival order). Per request kind:
//     submit to a full or empty queue, dequeue of an empty queue, bump of an
//     empty queue and unused codes: o_done in the cycle after the request.
//     submit: moves larger entries back one place at a time, from the tail.
//     dequeue: reads the head, then writes each later entry one place lower.
//     bump: one pass over the entries compacting survivors.
//   The walk goes entry by entry through the single RAM read port;
//   busy stays high for the whole walk and the result follows the next cycle.
//   Reset (synchronous, i_rst_n low) empties the queue and sets the current
//   generation to zero; RAM contents are left as they are and are only read
//   below the fill count.
`include "assert_macros.svh"

module generation_tagged_priority_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int GEN_BITS    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  gtpq_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output gtpq_pkg::t_rsp o_rsp
);

    import gtpq_pkg::*;

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int EW   = 21 + GEN_BITS;
    localparam int P_HI = GEN_BITS + 4;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [GEN_BITS-1:0]   r_gen, n_gen;
    logic [AW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_keep, n_keep;
    logic                  r_deq, n_deq;
    logic [EW-1:0]         r_new, n_new;
    logic [EW-1:0]         r_front, n_front;
    logic                  r_valid, n_valid;
    t_rsp                  r_rsp, n_rsp;

    logic                  accept;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [EW-1:0]         wdata;
    logic [AW-1:0]         raddr;
    logic [EW-1:0]         rdata;
    logic                  keep;
    logic [CW-1:0]         kept_next;

    gtpq_ram #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    function automatic t_rsp mk_rsp(
        input t_status             st,
        input logic [EW-1:0]       e,
        input logic                has_job,
        input logic [CW-1:0]       dropped,
        input logic [CW-1:0]       occ,
        input logic [GEN_BITS-1:0] gen
    );
        t_rsp r;
        r.status             = st;
        r.out_tag            = has_job ? e[EW-1 -: 16] : 16'd0;
        r.out_priority       = has_job ? e[P_HI -: 4] : 4'd0;
        r.out_pinned         = has_job ? e[GEN_BITS] : 1'b0;
        r.dropped_count      = 5'(dropped);
        r.occupancy          = 5'(occ);
        r.current_generation = 16'(gen);
        return r;
    endfunction

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_valid;
    assign o_rsp  = r_rsp;

    // Survivor test for the compaction walk: a dequeue keeps every entry.
    assign keep      = r_deq || rdata[GEN_BITS] || (rdata[GEN_BITS-1:0] == r_gen);
    assign kept_next = r_keep + CW'(keep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_gen   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_gen   <= n_gen;
            r_valid <= n_valid;
        end
        r_idx   <= n_idx;
        r_keep  <= n_keep;
        r_deq   <= n_deq;
        r_new   <= n_new;
        r_front <= n_front;
        r_rsp   <= n_rsp;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_gen   = r_gen;
        n_idx   = r_idx;
        n_keep  = r_keep;
        n_deq   = r_deq;
        n_new   = r_new;
        n_front = r_front;
        n_valid = 1'b0;
        n_rsp   = r_rsp;
        we      = 1'b0;
        waddr   = '0;
        wdata   = r_new;
        raddr   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_req.func)
                        FUNC_SUBMIT: begin
                            if (r_cnt == CW'(QUEUE_DEPTH)) begin
                                n_valid = 1'b1;
                                n_rsp   = mk_rsp(STAT_FULL, r_new, 1'b0, '0, r_cnt, r_gen);
                            end else begin
                                n_new = {i_req.job_tag, i_req.job_priority, i_req.job_pinned,
                                         GEN_BITS'(i_req.job_generation)};
                                if (r_cnt == '0) begin
                                    we      = 1'b1;
                                    wdata   = n_new;
                                    n_cnt   = CW'(1);
                                    n_valid = 1'b1;
                                    n_rsp   = mk_rsp(STAT_OK, r_new, 1'b0, '0, n_cnt, r_gen);
                                end else begin
                                    // start at the tail and move larger entries back
                                    raddr   = AW'(r_cnt - CW'(1));
                                    n_idx   = raddr;
                                    n_state = ST_INS;
                                end
                            end
                        end
                        FUNC_DEQUEUE: begin
                            if (r_cnt == '0) begin
                                n_valid = 1'b1;
                                n_rsp   = mk_rsp(STAT_EMPTY, r_new, 1'b0, '0, r_cnt, r_gen);
                            end else begin
                                n_state = ST_HEAD;
                            end
                        end
                        FUNC_BUMP: begin
                            n_gen = r_gen + GEN_BITS'(1);
                            if (r_cnt == '0) begin
                                n_valid = 1'b1;
                                n_rsp   = mk_rsp(STAT_BUMP, r_new, 1'b0, '0, r_cnt, n_gen);
                            end else begin
                                n_idx   = '0;
                                n_keep  = '0;
                                n_deq   = 1'b0;
                                n_state = ST_WALK;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                            n_rsp   = mk_rsp(STAT_OK, r_new, 1'b0, '0, r_cnt, r_gen);
                        end
                    endcase
                end
            end
            ST_INS: begin
                we    = 1'b1;
                waddr = r_idx + AW'(1);
                if (rdata[P_HI -: 4] > r_new[P_HI -: 4]) begin
                    wdata = rdata;
                    if (r_idx == '0) begin
                        n_state = ST_PUT;
                    end else begin
                        raddr = r_idx - AW'(1);
                        n_idx = raddr;
                    end
                end else begin
                    wdata   = r_new;
                    n_cnt   = r_cnt + CW'(1);
                    n_valid = 1'b1;
                    n_rsp   = mk_rsp(STAT_OK, r_new, 1'b0, '0, n_cnt, r_gen);
                    n_state = ST_IDLE;
                end
            end
            ST_PUT: begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = r_new;
                n_cnt   = r_cnt + CW'(1);
                n_valid = 1'b1;
                n_rsp   = mk_rsp(STAT_OK, r_new, 1'b0, '0, n_cnt, r_gen);
                n_state = ST_IDLE;
            end
            ST_HEAD: begin
                n_front = rdata;
                if (r_cnt == CW'(1)) begin
                    n_cnt   = '0;
                    n_valid = 1'b1;
                    n_rsp   = mk_rsp((!rdata[GEN_BITS] && (rdata[GEN_BITS-1:0] != r_gen))
                                     ? STAT_STALE : STAT_OK,
                                     rdata, 1'b1, '0, n_cnt, r_gen);
                    n_state = ST_IDLE;
                end else begin
                    // shift the rest down by one
                    raddr   = AW'(1);
                    n_idx   = raddr;
                    n_keep  = '0;
                    n_deq   = 1'b1;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                we    = keep;
                waddr = r_keep[AW-1:0];
                wdata = rdata;
                if (r_idx == AW'(r_cnt - CW'(1))) begin
                    n_cnt   = kept_next;
                    n_valid = 1'b1;
                    if (r_deq) begin
                        n_rsp = mk_rsp((!r_front[GEN_BITS] &&
                                        (r_front[GEN_BITS-1:0] != r_gen))
                                       ? STAT_STALE : STAT_OK,
                                       r_front, 1'b1, '0, kept_next, r_gen);
                    end else begin
                        n_rsp = mk_rsp(STAT_BUMP, r_front, 1'b0, r_cnt - kept_next,
                                       kept_next, r_gen);
                    end
                    n_state = ST_IDLE;
                end else begin
                    raddr  = r_idx + AW'(1);
                    n_idx  = raddr;
                    n_keep = kept_next;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(QUEUE_DEPTH),
        "fill count exceeds queue depth")
    `ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, accept, busy || o_done,
        "request neither in progress nor answered")
    `ASSERT_CLK(a_walk_order, i_clk, i_rst_n,
        (r_state != ST_WALK) || (r_keep <= CW'(r_idx)),
        "compaction write overtakes read")
    `ASSERT_CLK(a_ins_not_full, i_clk, i_rst_n,
        (r_state != ST_INS && r_state != ST_PUT) || (r_cnt != CW'(QUEUE_DEPTH)),
        "insertion into a full queue")

endmodule

// ===== bench/gtpq_checker.sv =====
// Result checker for the generation tagged priority queue bench.
// Watches the request and result channels, predicts each result and compares.
// Depends on gtpq_pkg.
module gtpq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  gtpq_pkg::t_req i_req,
    input  logic           i_done,
    input  gtpq_pkg::t_rsp i_rsp,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import gtpq_pkg::*;

    localparam int PEND_DEPTH = 8;

    typedef struct packed {
        logic [15:0] tag;
        logic [3:0]  prio;
        logic        pinned;
        logic [15:0] gen;
    } t_job;

    t_job        queued_jobs [QUEUE_DEPTH];
    int unsigned job_count;
    logic [15:0] gen_now;
    t_rsp        expected_rsps [PEND_DEPTH];
    logic [2:0]  exp_rd;
    logic [2:0]  exp_wr;
    int          exp_level;
    t_rsp        oldest_rsp;
    int          fail_total = 0;

    // Apply one request to the shadow queue and return the result it must give.
    function automatic t_rsp serve_request(t_req r);
        t_rsp        rsp;
        t_job        nj;
        t_job        front;
        int unsigned pos;
        int unsigned kept;
        rsp = '0;
        case (r.func)
            FUNC_SUBMIT: begin
                if (job_count >= QUEUE_DEPTH) begin
                    rsp.status = STAT_FULL;
                end else begin
                    nj = '{tag: r.job_tag, prio: r.job_priority, pinned: r.job_pinned,
                           gen: r.job_generation};
                    // go behind every job of equal or better priority
                    pos = 0;
                    while (pos < job_count && queued_jobs[pos].prio <= nj.prio) pos++;
                    for (int unsigned i = job_count; i > pos; i--)
                        queued_jobs[i] = queued_jobs[i - 1];
                    queued_jobs[pos] = nj;
                    job_count++;
                    rsp.status = STAT_OK;
                end
            end
            FUNC_DEQUEUE: begin
                if (job_count == 0) begin
                    rsp.status = STAT_EMPTY;
                end else begin
                    front = queued_jobs[0];
                    for (int unsigned i = 1; i < job_count; i++)
                        queued_jobs[i - 1] = queued_jobs[i];
                    job_count--;
                    rsp.status       = (!front.pinned && front.gen != gen_now) ? STAT_STALE
                                                                               : STAT_OK;
                    rsp.out_tag      = front.tag;
                    rsp.out_priority = front.prio;
                    rsp.out_pinned   = front.pinned;
                end
            end
            FUNC_BUMP: begin
                gen_now = gen_now + 16'd1;
                kept = 0;
                for (int unsigned i = 0; i < job_count; i++) begin
                    if (queued_jobs[i].pinned || queued_jobs[i].gen == gen_now) begin
                        queued_jobs[kept] = queued_jobs[i];
                        kept++;
                    end
                end
                rsp.dropped_count = 5'(job_count - kept);
                job_count = kept;
                rsp.status = STAT_BUMP;
            end
            default: rsp.status = STAT_OK;
        endcase
        rsp.occupancy          = 5'(job_count);
        rsp.current_generation = gen_now;
        return rsp;
    endfunction

    function automatic int check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v == act_v) return 0;
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            job_count = 0;
            gen_now   = '0;
            exp_rd    = '0;
            exp_wr    = '0;
            exp_level = 0;
            o_pending <= 0;
        end else begin
            // a result never belongs to a request taken at the same edge: compare first
            if (i_done) begin
                if (exp_level == 0) begin
                    $error("result with no request outstanding: status %0d",
                           int'(i_rsp.status));
                    fail_total++;
                end else begin
                    oldest_rsp = expected_rsps[exp_rd];
                    exp_rd     = exp_rd + 3'd1;
                    exp_level--;
                    fail_total += check_field("status", oldest_rsp.status, i_rsp.status);
                    fail_total += check_field("out_tag", oldest_rsp.out_tag, i_rsp.out_tag);
                    fail_total += check_field("out_priority", oldest_rsp.out_priority,
                                              i_rsp.out_priority);
                    fail_total += check_field("out_pinned", oldest_rsp.out_pinned,
                                              i_rsp.out_pinned);
                    fail_total += check_field("dropped_count", oldest_rsp.dropped_count,
                                              i_rsp.dropped_count);
                    fail_total += check_field("occupancy", oldest_rsp.occupancy,
                                              i_rsp.occupancy);
                    fail_total += check_field("current_generation",
                                              oldest_rsp.current_generation,
                                              i_rsp.current_generation);
                end
            end
            if (i_start && !i_busy) begin
                if (exp_level >= PEND_DEPTH) begin
                    $error("too many requests outstanding: %0d", exp_level);
                    fail_total++;
                end else begin
                    expected_rsps[exp_wr] = serve_request(i_req);
                    exp_wr = exp_wr + 3'd1;
                    exp_level++;
                end
            end
            o_pending <= exp_level;
        end
        o_fail_count <= fail_total;
    end

endmodule

// ===== bench/generation_tagged_priority_queue_tb.sv =====
// Testbench top for the generation tagged priority queue.
// Drives directed, generation and random requests; gtpq_checker judges the results.
// Depends on gtpq_pkg, gtpq_checker and the queue RTL.
module generation_tagged_priority_queue_tb ();
    timeunit 1ns;
    timeprecision 1ps;

    import gtpq_pkg::*;

    localparam int    QUEUE_DEPTH  = 16;
    localparam int    RANDOM_ITEMS = 1700;
    localparam int    DRAIN_CYCLES = 40;
    localparam t_func FUNC_UNUSED  = t_func'(2'd3);

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_req        i_req;
    logic        busy;
    logic        o_done;
    t_rsp        o_rsp;
    int          fail_count;
    int          pending_count;
    int unsigned bumps_done;
    int          burst_left;

    generation_tagged_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .GEN_BITS   (16)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    gtpq_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (i_req),
        .i_done      (o_done),
        .i_rsp       (o_rsp),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("** generation_tagged_priority_queue: FAILED **");
        $finish;
    end

    function automatic t_req job_req(logic [3:0] prio, logic pinned, logic [15:0] gen);
        t_req r;
        r.func           = FUNC_SUBMIT;
        r.job_tag        = 16'($urandom);
        r.job_priority   = prio;
        r.job_pinned     = pinned;
        r.job_generation = gen;
        return r;
    endfunction

    // Non-submit request; payload fields are random noise.
    function automatic t_req op_req(t_func f);
        t_req r;
        r = job_req(4'($urandom), 1'($urandom), 16'($urandom));
        r.func = f;
        return r;
    endfunction

    // Generation close to the current one, so both stale and fresh jobs occur.
    function automatic logic [15:0] near_gen();
        logic [15:0] g;
        g = bumps_done[15:0];
        case ($urandom_range(5))
            0, 1:    return g;
            2:       return g + 16'd1;
            3:       return g - 16'd1;
            4:       return g + 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    // Hold the request until taken, then maybe pause before the next burst.
    task automatic issue(input t_req r);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (r.func == FUNC_BUMP) bumps_done++;
        burst_left--;
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 30 : 6)) @(posedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
        end
    endtask

    initial begin
        t_req r;
        int   fill_mode;
        int   roll;
        int   submit_share;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        bumps_done = 0;
        burst_left = 5;
        fill_mode  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue corner cases
        issue(op_req(FUNC_DEQUEUE));
        issue(op_req(FUNC_BUMP));
        issue(op_req(FUNC_UNUSED));
        // fill with extreme fields, ties in priority and mixed generations
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            r = job_req((k % 4 == 0) ? 4'd15 : (k % 4 == 1) ? 4'd0 : 4'd7, k[1],
                        (k / 4 == 0) ? 16'h0000 :
                        (k / 4 == 1) ? 16'hFFFF :
                        (k / 4 == 2) ? bumps_done[15:0] : bumps_done[15:0] + 16'd1);
            if (k == 0) r.job_tag = 16'h0000;
            if (k == 1) r.job_tag = 16'hFFFF;
            issue(r);
        end
        issue(job_req(4'd3, 1'b0, 16'h0001));
        issue(op_req(FUNC_UNUSED));
        issue(op_req(FUNC_DEQUEUE));
        issue(op_req(FUNC_BUMP));
        repeat (2) issue(op_req(FUNC_DEQUEUE));

        // drain, then queue jobs just ahead of the current generation and bump past them
        repeat (QUEUE_DEPTH + 1) issue(op_req(FUNC_DEQUEUE));
        issue(job_req(4'd5, 1'b0, bumps_done[15:0] + 16'd1));
        issue(job_req(4'd5, 1'b0, bumps_done[15:0] + 16'd3));
        issue(job_req(4'd2, 1'b0, bumps_done[15:0] + 16'd4));
        issue(job_req(4'd9, 1'b1, bumps_done[15:0] + 16'd5));
        issue(job_req(4'd2, 1'b0, bumps_done[15:0] + 16'd2));
        repeat (4) issue(op_req(FUNC_BUMP));
        issue(op_req(FUNC_DEQUEUE));
        issue(op_req(FUNC_BUMP));
        repeat (4) issue(op_req(FUNC_DEQUEUE));

        // random traffic, alternating fill-heavy, drain-heavy and balanced stretches
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) fill_mode = $urandom_range(2);
            submit_share = (fill_mode == 0) ? 75 : (fill_mode == 1) ? 30 : 50;
            roll = $urandom_range(99);
            if (roll < submit_share)
                issue(job_req($urandom_range(1) ? 4'($urandom) : 4'($urandom_range(3)),
                              1'($urandom_range(3) == 0), near_gen()));
            else if (roll < 90)
                issue(op_req(FUNC_DEQUEUE));
            else if (roll < 98)
                issue(op_req(FUNC_BUMP));
            else
                issue(op_req(FUNC_UNUSED));
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("** generation_tagged_priority_queue: PASSED **");
        else
            $display("** generation_tagged_priority_queue: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/gtpq_pkg.sv
rtl/core/gtpq_ram.sv
rtl/core/generation_tagged_priority_queue.sv
bench/gtpq_checker.sv
bench/generation_tagged_priority_queue_tb.sv
